// File: hdl/lbpt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lbpt_pkg
// Shared types and constants for the LED blink pattern timer.
// ----------------------------------------------------------------------------
package lbpt_pkg;

    localparam int CFG_W          = 32;
    localparam int CFG_IDX_W      = 1;
    localparam int ACTION_W       = 3;
    localparam int REQ_COUNT_W    = 16;
    localparam int RSP_COUNT_W    = 16;
    localparam int TIME_BITS_DEF  = 32;
    localparam int COUNT_BITS_DEF = 16;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ON_TICKS  = 1'd0,
        REG_OFF_TICKS = 1'd1
    } t_cfg_reg;

    typedef enum logic [ACTION_W-1:0] {
        ACT_TICK  = 3'd0,
        ACT_SET   = 3'd1,
        ACT_STOP  = 3'd2,
        ACT_START = 3'd3,
        ACT_TIMES = 3'd4
    } t_action;

    typedef struct packed {
        logic [ACTION_W-1:0]    action;
        logic                   level;
        logic [REQ_COUNT_W-1:0] count;
    } t_req;

    typedef struct packed {
        logic                   led_on;
        logic                   is_paused;
        logic [RSP_COUNT_W-1:0] flashes_left;
    } t_rsp;

    typedef struct packed {
        logic led_level;
        logic stopped;
    } t_flags;

endpackage

// File: hdl/lbpt_cfg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lbpt_cfg
// On and off duration registers written through the plain write port.
// ----------------------------------------------------------------------------
module lbpt_cfg (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [lbpt_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [lbpt_pkg::CFG_W-1:0]   i_cfg_data,
    output logic [lbpt_pkg::CFG_W-1:0]   o_on_ticks,
    output logic [lbpt_pkg::CFG_W-1:0]   o_off_ticks
);
    import lbpt_pkg::*;

    logic [CFG_W-1:0] r_on_ticks;
    logic [CFG_W-1:0] r_off_ticks;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_on_ticks  <= '0;
            r_off_ticks <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_ON_TICKS:  r_on_ticks  <= i_cfg_data;
                REG_OFF_TICKS: r_off_ticks <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign o_on_ticks  = r_on_ticks;
    assign o_off_ticks = r_off_ticks;

endmodule

// File: hdl/lbpt_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lbpt_step
// Next-state logic for one request: tick, set level, stop, start, flash.
// ----------------------------------------------------------------------------
module lbpt_step #(
    parameter int TIME_BITS  = lbpt_pkg::TIME_BITS_DEF,
    parameter int COUNT_BITS = lbpt_pkg::COUNT_BITS_DEF
) (
    input  lbpt_pkg::t_req               i_req,
    input  logic [lbpt_pkg::CFG_W-1:0]   i_on_ticks,
    input  logic [lbpt_pkg::CFG_W-1:0]   i_off_ticks,
    input  lbpt_pkg::t_flags             i_flags,
    input  logic [TIME_BITS-1:0]         i_elapsed,
    input  logic [COUNT_BITS-1:0]        i_remaining,
    output lbpt_pkg::t_flags             o_flags,
    output logic [TIME_BITS-1:0]         o_elapsed,
    output logic [COUNT_BITS-1:0]        o_remaining
);
    import lbpt_pkg::*;

    localparam int CMP_W = (TIME_BITS > CFG_W) ? TIME_BITS : CFG_W;

    logic [TIME_BITS-1:0] el_inc;
    logic [CFG_W-1:0]     dur;
    logic                 reached;
    logic                 blocked;

    always_comb begin
        el_inc  = (i_elapsed == {TIME_BITS{1'b1}}) ? i_elapsed
                                                   : i_elapsed + TIME_BITS'(1);
        dur     = i_flags.led_level ? i_on_ticks : i_off_ticks;
        reached = CMP_W'(el_inc) >= CMP_W'(dur);
        blocked = i_flags.led_level ? (i_off_ticks == '0) : (i_on_ticks == '0);
    end

    always_comb begin
        o_flags     = i_flags;
        o_elapsed   = i_elapsed;
        o_remaining = i_remaining;
        unique case (i_req.action)
            ACT_TICK: begin
                if (!i_flags.stopped) begin
                    o_elapsed = el_inc;
                    if (reached && !blocked) begin
                        o_elapsed         = '0;
                        o_flags.led_level = !i_flags.led_level;
                        // falling edge uses up one flash
                        if (i_flags.led_level) begin
                            if (i_remaining > COUNT_BITS'(1)) begin
                                o_remaining = i_remaining - COUNT_BITS'(1);
                            end else if (i_remaining == COUNT_BITS'(1)) begin
                                o_remaining     = '0;
                                o_flags.stopped = 1'b1;
                            end
                        end
                    end
                end
            end
            ACT_SET: begin
                o_flags.led_level = i_req.level;
            end
            ACT_STOP: begin
                o_flags.stopped = 1'b1;
            end
            ACT_START: begin
                o_flags.stopped = 1'b0;
                o_elapsed       = '0;
            end
            ACT_TIMES: begin
                o_remaining       = COUNT_BITS'(i_req.count);
                o_flags.led_level = 1'b1;
                o_flags.stopped   = 1'b0;
                o_elapsed         = '0;
            end
            default: ;
        endcase
    end

endmodule

// File: hdl/led_blink_pattern_timer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// led_blink_pattern_timer
// LED blink controller with repeat count: one request in, one response out.
//
//   channel   direction  handshake                    payload
//   request   in         i_req_valid / o_req_ready    i_req (action, level, count)
//   response  out        o_rsp_valid / i_rsp_ready    o_rsp (led_on, is_paused,
//                                                            flashes_left)
//   config    in         i_cfg_we                     i_cfg_idx, i_cfg_data
//
// one request per cycle while responses are taken; the response follows acceptance
// through the request register, then the state and response registers
// reset clears the durations, the state (off, paused) and both valid flags
// a stalled response holds the response register; a waiting request holds
// in the request register, so the request side backs up one stage later
// ----------------------------------------------------------------------------
module led_blink_pattern_timer #(
    parameter int TIME_BITS  = lbpt_pkg::TIME_BITS_DEF,
    parameter int COUNT_BITS = lbpt_pkg::COUNT_BITS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [lbpt_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [lbpt_pkg::CFG_W-1:0]     i_cfg_data,
    input  logic                           i_req_valid,
    output logic                           o_req_ready,
    input  lbpt_pkg::t_req                 i_req,
    output logic                           o_rsp_valid,
    input  logic                           i_rsp_ready,
    output lbpt_pkg::t_rsp                 o_rsp
);
    import lbpt_pkg::*;

    logic [CFG_W-1:0]      on_ticks;
    logic [CFG_W-1:0]      off_ticks;

    t_req                  r_req;
    logic                  r_req_valid;
    t_flags                r_flags;
    logic [TIME_BITS-1:0]  r_elapsed;
    logic [COUNT_BITS-1:0] r_remaining;
    t_rsp                  r_rsp;
    logic                  r_rsp_valid;

    t_flags                n_flags;
    logic [TIME_BITS-1:0]  n_elapsed;
    logic [COUNT_BITS-1:0] n_remaining;

    logic                  adv;

    lbpt_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .o_on_ticks  (on_ticks),
        .o_off_ticks (off_ticks)
    );

    lbpt_step #(
        .TIME_BITS  (TIME_BITS),
        .COUNT_BITS (COUNT_BITS)
    ) u_step (
        .i_req       (r_req),
        .i_on_ticks  (on_ticks),
        .i_off_ticks (off_ticks),
        .i_flags     (r_flags),
        .i_elapsed   (r_elapsed),
        .i_remaining (r_remaining),
        .o_flags     (n_flags),
        .o_elapsed   (n_elapsed),
        .o_remaining (n_remaining)
    );

    assign adv         = r_req_valid && (!r_rsp_valid || i_rsp_ready);
    assign o_req_ready = !r_req_valid || adv;

    // request register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_req_valid <= 1'b0;
        end else if (o_req_ready) begin
            r_req_valid <= i_req_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_req_ready && i_req_valid) begin
            r_req <= i_req;
        end
    end

    // state and response registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flags.led_level <= 1'b0;
            r_flags.stopped   <= 1'b1;
            r_elapsed         <= '0;
            r_remaining       <= '0;
            r_rsp_valid       <= 1'b0;
        end else if (adv) begin
            r_flags     <= n_flags;
            r_elapsed   <= n_elapsed;
            r_remaining <= n_remaining;
            r_rsp_valid <= 1'b1;
        end else if (i_rsp_ready) begin
            r_rsp_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_rsp.led_on       <= n_flags.led_level;
            r_rsp.is_paused    <= n_flags.stopped;
            r_rsp.flashes_left <= RSP_COUNT_W'(n_remaining);
        end
    end

    assign o_rsp_valid = r_rsp_valid;
    assign o_rsp       = r_rsp;

    a_paused_tick_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (adv && r_req.action == ACT_TICK && r_flags.stopped)
            |-> (n_elapsed == r_elapsed && n_flags == r_flags
                 && n_remaining == r_remaining))
        else $error("tick while paused changed state");

    a_flip_clears_elapsed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (adv && r_req.action == ACT_TICK && n_flags.led_level != r_flags.led_level)
            |-> (n_elapsed == '0))
        else $error("level flip without elapsed clear");

    a_remaining_no_rise: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (adv && r_req.action != ACT_TIMES) |-> (n_remaining <= r_remaining))
        else $error("remaining count rose outside flash command");

    a_rsp_matches_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp_valid |-> (o_rsp.led_on == r_flags.led_level
                         && o_rsp.is_paused == r_flags.stopped))
        else $error("response out of step with state");

endmodule
